### sv/km_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km_pkg
// shared types and constants of the k-means assign and update engine
// ----------------------------------------------------------------------------
package km_pkg;

  localparam int NC     = 128;   // center slots
  localparam int ND     = 1024;  // elements per vector
  localparam int CW     = 7;     // center index width
  localparam int DW     = 10;    // element index width
  localparam int NCW    = 8;     // centers_in_use width
  localparam int NDW    = 11;    // dims_in_use width
  localparam int VW     = 16;    // element value width
  localparam int SUMW   = 37;    // per element sum width
  localparam int CNTW   = 21;    // member count width
  localparam int DISTW  = 48;    // distance width
  localparam int TOTW   = 63;    // pass total width
  localparam int EMPW   = 8;     // empty center count width
  localparam int MAGW   = VW + 1;

  localparam logic [CNTW-1:0] CNT_MAX = {CNTW{1'b1}};
  localparam logic [DW-1:0]   K_LAST  = {DW{1'b1}};

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // result kinds
  localparam logic RK_SAMPLE = 1'b0;
  localparam logic RK_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic CFG_CENTERS = 1'b0;
  localparam logic CFG_DIMS    = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic          load_we;
    logic          smp_we;
    logic          elem_issue;
    logic          pos_adv;
    logic          cnt_rd_best;
    logic          cnt_chk;
    logic          acc_issue;
    logic          smp_done;
    logic          ucnt_rd;
    logic          uchk;
    logic          urd;
    logic          div_start;
    logic          cwr_upd;
    logic          upd_done;
    logic [CW-1:0] c_idx;
    logic [DW-1:0] k_idx;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;
    logic cnt_ok;
    logic ucnt_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

### sv/km_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module km_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/km_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km_div
// restoring divider, signed sum by unsigned count, one quotient bit a cycle
// ----------------------------------------------------------------------------
module km_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [km_pkg::SUMW-1:0]    dividend,
  input  logic [km_pkg::CNTW-1:0]    divisor,
  output logic                       done,
  output logic [km_pkg::VW-1:0]      quotient
);
  import km_pkg::*;

  localparam int ITW = $clog2(SUMW + 1);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [ITW-1:0]  it_r, it_nxt;
  logic [SUMW-1:0] dq_r, dq_nxt;
  logic [CNTW:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic [CNTW:0]   rem_sh;
  logic            qbit;

  // one restoring step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    it_nxt   = it_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[CNTW-1:0], dq_r[SUMW-1]};
    qbit     = (rem_sh >= {1'b0, dvs_r});
    if (start) begin
      busy_nxt = 1'b1;
      it_nxt   = ITW'(SUMW);
      dq_nxt   = dividend[SUMW-1] ? (~dividend + 1'b1) : dividend;
      neg_nxt  = dividend[SUMW-1];
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      dq_nxt  = {dq_r[SUMW-2:0], qbit};
      it_nxt  = it_r - 1'b1;
      if (it_r == ITW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    it_r  <= it_nxt;
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // quotient magnitude fits the element width, truncated toward zero
  assign done     = done_r;
  assign quotient = neg_r ? (~dq_r[VW-1:0] + 1'b1) : dq_r[VW-1:0];

endmodule

### sv/km_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km_ctrl
// sequencer of the engine: center sweeps, sum sweeps and center update
// ----------------------------------------------------------------------------
module km_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_operation,
  input  logic [km_pkg::NCW-1:0]  nc_eff,
  input  logic [km_pkg::NDW-1:0]  nd_eff,
  input  km_pkg::dp_sts_t         sts,
  output km_pkg::dp_cmd_t         cmd
);
  import km_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_ELEM   = 14'b00000000000010,
    ST_EDRAIN = 14'b00000000000100,
    ST_CNT    = 14'b00000000001000,
    ST_CNTW   = 14'b00000000010000,
    ST_ACC    = 14'b00000000100000,
    ST_ADRAIN = 14'b00000001000000,
    ST_SOUT   = 14'b00000010000000,
    ST_UCNT   = 14'b00000100000000,
    ST_UCHK   = 14'b00001000000000,
    ST_URD    = 14'b00010000000000,
    ST_UDST   = 14'b00100000000000,
    ST_UDIV   = 14'b01000000000000,
    ST_UOUT   = 14'b10000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [DW-1:0] k_r, k_nxt;
  logic [1:0]    drn_r, drn_nxt;
  logic          c_last, k_last_upd;

  assign c_last     = ({1'b0, c_r} == (nc_eff - 1'b1));
  assign k_last_upd = ({1'b0, k_r} == (nd_eff - 1'b1));

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    k_nxt     = k_r;
    drn_nxt   = drn_r;
    cmd       = '0;
    cmd.c_idx = c_r;
    cmd.k_idx = k_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(in_operation))
            OP_LOAD:   cmd.load_we = 1'b1;
            OP_SAMPLE: begin
              cmd.smp_we = 1'b1;
              c_nxt      = '0;
              state_nxt  = ST_ELEM;
            end
            OP_UPDATE: begin
              c_nxt     = '0;
              state_nxt = ST_UCNT;
            end
            default: ;
          endcase
        end
      end
      ST_ELEM: begin
        cmd.elem_issue = 1'b1;
        if (c_last) begin
          drn_nxt   = '0;
          state_nxt = ST_EDRAIN;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      ST_EDRAIN: begin
        drn_nxt = drn_r + 1'b1;
        if (drn_r == 2'd2) begin
          if (sts.last) begin
            state_nxt = ST_CNT;
          end else begin
            cmd.pos_adv = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_CNT: begin
        cmd.cnt_rd_best = 1'b1;
        state_nxt       = ST_CNTW;
      end
      ST_CNTW: begin
        cmd.cnt_chk = 1'b1;
        k_nxt       = '0;
        state_nxt   = sts.cnt_ok ? ST_ACC : ST_SOUT;
      end
      ST_ACC: begin
        cmd.acc_issue = 1'b1;
        if (k_r == K_LAST) begin
          state_nxt = ST_ADRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_ADRAIN: state_nxt = ST_SOUT;
      ST_SOUT: begin
        if (sts.out_free) begin
          cmd.smp_done = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_UCNT: begin
        cmd.ucnt_rd = 1'b1;
        state_nxt   = ST_UCHK;
      end
      ST_UCHK: begin
        cmd.uchk = 1'b1;
        k_nxt    = '0;
        if (!sts.ucnt_zero) begin
          state_nxt = ST_URD;
        end else if (c_last) begin
          state_nxt = ST_UOUT;
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = ST_UCNT;
        end
      end
      ST_URD: begin
        cmd.urd   = 1'b1;
        state_nxt = ST_UDST;
      end
      ST_UDST: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_UDIV;
      end
      ST_UDIV: begin
        if (sts.div_done) begin
          cmd.cwr_upd = 1'b1;
          if (!k_last_upd) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_URD;
          end else if (c_last) begin
            state_nxt = ST_UOUT;
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = ST_UCNT;
          end
        end
      end
      ST_UOUT: begin
        if (sts.out_free) begin
          cmd.upd_done = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      c_r     <= '0;
      k_r     <= '0;
      drn_r   <= '0;
    end else begin
      state_r <= state_nxt;
      c_r     <= c_nxt;
      k_r     <= k_nxt;
      drn_r   <= drn_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_we |-> (state_r == ST_IDLE && in_valid))
    else $error("center load outside idle");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_UDIV && !sts.div_done))
    else $error("divider finished too early");
  a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ELEM && state_nxt == ST_EDRAIN) |=> ##2 (drn_r == 2'd2))
    else $error("element drain length wrong");
`endif

endmodule

### sv/km_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km_dp
// datapath: stores, distance pipeline, sum sweep, divider and result register
// ----------------------------------------------------------------------------
module km_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  km_pkg::dp_cmd_t              cmd,
  output km_pkg::dp_sts_t              sts,
  input  logic [km_pkg::NDW-1:0]       nd_eff,
  input  logic [km_pkg::CW-1:0]        in_center_index,
  input  logic [km_pkg::DW-1:0]        in_element_index,
  input  logic signed [km_pkg::VW-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [km_pkg::CW-1:0]        out_nearest_center,
  output logic [km_pkg::DISTW-1:0]     out_min_distance,
  output logic [km_pkg::TOTW-1:0]      out_total_distance,
  output logic [km_pkg::EMPW-1:0]      out_empty_centers
);
  import km_pkg::*;

  localparam int NCD = NC * ND;
  localparam int CDW = CW + DW;

  // control state
  logic [DW-1:0]    pos_r;
  logic [NC-1:0]    pval_r;
  logic [NC-1:0]    cval_r;
  logic [TOTW-1:0]  total_r;
  logic [EMPW-1:0]  empty_r;
  logic             v1_r, v2_r, v3_r, a1_v_r;
  logic             out_valid_r;

  // payload
  logic signed [VW-1:0] sval_r;
  logic [CW-1:0]    c1_r, c2_r, c3_r;
  logic [MAGW-1:0]  mag2_r;
  logic [DISTW-1:0] part2_r, part3_r;
  logic [2*MAGW-1:0] sq3_r;
  logic [CW-1:0]    best_c_r;
  logic [DISTW-1:0] best_d_r;
  logic             first_r;
  logic [DW-1:0]    a1_k_r;
  logic [CNTW-1:0]  ucnt_r;
  logic             kind_r;
  logic [CW-1:0]    onc_r;
  logic [DISTW-1:0] omd_r;
  logic [TOTW-1:0]  otot_r;
  logic [EMPW-1:0]  oemp_r;

  // ram ports
  logic [VW-1:0]    cq, sbq, div_q;
  logic [DISTW-1:0] pq;
  logic [CNTW-1:0]  cntq;
  logic [SUMW-1:0]  sumq;
  logic             cst_we;
  logic [CDW-1:0]   cst_wa;
  logic [VW-1:0]    cst_wd;
  logic [CW-1:0]    cnt_ra;
  logic [CDW-1:0]   sum_ra;
  logic [SUMW-1:0]  sum_wd;
  logic             div_done;

  // combinational terms
  logic signed [MAGW-1:0] diff;
  logic [MAGW-1:0]  mag;
  logic [DISTW-1:0] part1;
  logic [DISTW-1:0] nsum;
  logic [CNTW-1:0]  cnt_cur;
  logic [CW-1:0]    cnt_vi;
  logic [TOTW:0]    tsum;
  logic [TOTW-1:0]  tnew;
  logic [SUMW-1:0]  acc_old, acc_add;
  logic             last_w, out_free;

  assign last_w   = ({1'b0, pos_r} + 1'b1) >= nd_eff;
  assign out_free = !out_valid_r || out_ready;

  // center store: loads and update writes, distance reads
  assign cst_we = cmd.load_we || cmd.cwr_upd;
  assign cst_wa = cmd.load_we ? {in_center_index, in_element_index} : {cmd.c_idx, cmd.k_idx};
  assign cst_wd = cmd.load_we ? in_value : div_q;

  km_ram #(.WIDTH(VW), .DEPTH(NCD)) u_cst (
    .clk(clk), .we(cst_we), .waddr(cst_wa), .wdata(cst_wd),
    .raddr({cmd.c_idx, pos_r}), .rdata(cq)
  );

  km_ram #(.WIDTH(DISTW), .DEPTH(NC)) u_pst (
    .clk(clk), .we(v3_r), .waddr(c3_r), .wdata(nsum),
    .raddr(cmd.c_idx), .rdata(pq)
  );

  km_ram #(.WIDTH(VW), .DEPTH(ND)) u_smp (
    .clk(clk), .we(cmd.smp_we), .waddr(pos_r), .wdata(in_value),
    .raddr(cmd.k_idx), .rdata(sbq)
  );

  // member counts, valid bit per center stands for zero
  assign cnt_ra  = cmd.cnt_rd_best ? best_c_r : cmd.c_idx;
  assign cnt_vi  = cmd.cnt_chk ? best_c_r : cmd.c_idx;
  assign cnt_cur = cval_r[cnt_vi] ? cntq : '0;

  km_ram #(.WIDTH(CNTW), .DEPTH(NC)) u_cnt (
    .clk(clk), .we(cmd.cnt_chk && (cnt_cur != CNT_MAX)), .waddr(best_c_r),
    .wdata(cnt_cur + 1'b1), .raddr(cnt_ra), .rdata(cntq)
  );

  // sum store, a row with no members reads as zero
  assign sum_ra  = cmd.acc_issue ? {best_c_r, cmd.k_idx} : {cmd.c_idx, cmd.k_idx};
  assign acc_old = first_r ? '0 : sumq;
  assign acc_add = ({1'b0, a1_k_r} < nd_eff) ? {{(SUMW-VW){sbq[VW-1]}}, sbq} : '0;
  assign sum_wd  = acc_old + acc_add;

  km_ram #(.WIDTH(SUMW), .DEPTH(NCD)) u_sum (
    .clk(clk), .we(a1_v_r), .waddr({best_c_r, a1_k_r}), .wdata(sum_wd),
    .raddr(sum_ra), .rdata(sumq)
  );

  km_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(sumq),
    .divisor(ucnt_r), .done(div_done), .quotient(div_q)
  );

  // distance pipeline terms
  assign diff  = $signed({sval_r[VW-1], sval_r}) - $signed({cq[VW-1], cq});
  assign mag   = diff[MAGW-1] ? MAGW'(-diff) : MAGW'(diff);
  assign part1 = pval_r[c1_r] ? pq : '0;
  assign nsum  = part3_r + DISTW'(sq3_r);

  // saturating pass total
  assign tsum = {1'b0, total_r} + (TOTW+1)'(best_d_r);
  assign tnew = tsum[TOTW] ? {TOTW{1'b1}} : tsum[TOTW-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      pval_r      <= '0;
      cval_r      <= '0;
      total_r     <= '0;
      empty_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      a1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r   <= cmd.elem_issue;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      a1_v_r <= cmd.acc_issue;
      if (v3_r) begin
        pval_r[c3_r] <= 1'b1;
      end
      if (cmd.cnt_chk && (cnt_cur != CNT_MAX)) begin
        cval_r[best_c_r] <= 1'b1;
      end
      if (cmd.pos_adv) begin
        pos_r <= pos_r + 1'b1;
      end
      if (cmd.uchk && (cnt_cur == '0)) begin
        empty_r <= empty_r + 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.smp_done) begin
        out_valid_r <= 1'b1;
        total_r     <= tnew;
        pos_r       <= '0;
        pval_r      <= '0;
      end
      if (cmd.upd_done) begin
        out_valid_r <= 1'b1;
        total_r     <= '0;
        empty_r     <= '0;
        pos_r       <= '0;
        pval_r      <= '0;
        cval_r      <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.smp_we) begin
      sval_r <= in_value;
    end
    c1_r    <= cmd.c_idx;
    c2_r    <= c1_r;
    mag2_r  <= mag;
    part2_r <= part1;
    c3_r    <= c2_r;
    sq3_r   <= mag2_r * mag2_r;
    part3_r <= part2_r;
    a1_k_r  <= cmd.k_idx;
    // running minimum, lowest index wins ties
    if (v3_r && last_w && ((c3_r == '0) || (nsum < best_d_r))) begin
      best_c_r <= c3_r;
      best_d_r <= nsum;
    end
    if (cmd.cnt_chk) begin
      first_r <= (cnt_cur == '0);
    end
    if (cmd.uchk) begin
      ucnt_r <= cnt_cur;
    end
    if (cmd.smp_done) begin
      kind_r <= RK_SAMPLE;
      onc_r  <= best_c_r;
      omd_r  <= best_d_r;
      otot_r <= tnew;
      oemp_r <= '0;
    end
    if (cmd.upd_done) begin
      kind_r <= RK_UPDATE;
      onc_r  <= '0;
      omd_r  <= '0;
      otot_r <= total_r;
      oemp_r <= empty_r;
    end
  end

  assign sts.last      = last_w;
  assign sts.cnt_ok    = (cnt_cur != CNT_MAX);
  assign sts.ucnt_zero = (cnt_cur == '0);
  assign sts.div_done  = div_done;
  assign sts.out_free  = out_free;

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_nearest_center = onc_r;
  assign out_min_distance   = omd_r;
  assign out_total_distance = otot_r;
  assign out_empty_centers  = oemp_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.smp_done || cmd.upd_done) |-> out_free)
    else $error("result register overwritten");
  a_smp_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.smp_done |=> (pval_r == '0 && pos_r == '0))
    else $error("partial distances not cleared after sample");
  a_cst_port: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cwr_upd |-> !cmd.load_we)
    else $error("center store write conflict");
`endif

endmodule

### sv/kmeans_assign_and_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_top
// lloyd k-means engine: nearest center search, sum update and center update
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    operation, center/element index, value
// out_      output     out_valid / out_ready  kind, nearest, min/total distance, empty
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// load item: written to the center store from idle. sample element: one center per
// cycle through the center and partial distance memories plus a 3 stage drain.
// the last element adds a sweep of the sum row of the winner.
// update: a count read and check per center in use plus a division per element of
// each center with members (one quotient bit a cycle). no clearing pass after reset.
// a waiting result holds the block only when the next result is due.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [km_pkg::CW-1:0]        in_center_index,
  input  logic [km_pkg::DW-1:0]        in_element_index,
  input  logic signed [km_pkg::VW-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_result_kind,
  output logic [km_pkg::CW-1:0]        out_nearest_center,
  output logic [km_pkg::DISTW-1:0]     out_min_distance,
  output logic [km_pkg::TOTW-1:0]      out_total_distance,
  output logic [km_pkg::EMPW-1:0]      out_empty_centers,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [km_pkg::NDW-1:0]       cfg_data
);
  import km_pkg::*;

  logic [NCW-1:0] nc_r;
  logic [NDW-1:0] nd_r;
  logic [NCW-1:0] nc_eff;
  logic [NDW-1:0] nd_eff;
  dp_cmd_t        cmd;
  dp_sts_t        sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NCW'(NC);
      nd_r <= NDW'(ND);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTERS: nc_r <= cfg_data[NCW-1:0];
        CFG_DIMS:    nd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to the supported range
  assign nc_eff = (nc_r == '0) ? NCW'(1) : ((nc_r > NCW'(NC)) ? NCW'(NC) : nc_r);
  assign nd_eff = (nd_r == '0) ? NDW'(1) : ((nd_r > NDW'(ND)) ? NDW'(ND) : nd_r);

  km_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .nc_eff(nc_eff), .nd_eff(nd_eff),
    .sts(sts), .cmd(cmd)
  );

  km_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .nd_eff(nd_eff),
    .in_center_index(in_center_index), .in_element_index(in_element_index),
    .in_value(in_value), .out_valid(out_valid), .out_ready(out_ready),
    .out_result_kind(out_result_kind), .out_nearest_center(out_nearest_center),
    .out_min_distance(out_min_distance), .out_total_distance(out_total_distance),
    .out_empty_centers(out_empty_centers)
  );

endmodule
